// ----- hdl/ukfq_pkg.sv -----
`default_nettype none

package ukfq_pkg;

	localparam int DEPTH = 16;
	localparam int KEY_W = 31;
	localparam int CNT_W = 5;
	localparam int POS_W = 5;
	localparam int IDX_W = $clog2(DEPTH);

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_POP    = 2'd1,
		MODE_READ   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/unique_key_fifo_queue_top.sv -----
// a request beat is held in the stage-one registers, and its result is registered when the output register is free
// throughput: one request per cycle while the result side takes beats
// the head sits in cell zero; a pop shifts every cell one place toward the head
// asynchronous active-low reset empties the queue and clears the output valid flag
// cell contents are not reset; only slots below the count are ever read
`default_nettype none

module unique_key_fifo_queue_top
	import ukfq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       mode,
	input  wire logic [KEY_W-1:0] key_in,
	input  wire logic [KEY_W-1:0] value_in,
	input  wire logic [POS_W-1:0] position,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [1:0]       status,
	output logic      [KEY_W-1:0] key_out,
	output logic      [KEY_W-1:0] value_out,
	output logic      [CNT_W-1:0] count
);

	logic             req_valid_q;
	logic [1:0]       mode_s1;
	logic [KEY_W-1:0] key_s1;
	logic [KEY_W-1:0] value_s1;
	logic [POS_W-1:0] position_s1;

	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [KEY_W-1:0] key_out_q;
	logic [KEY_W-1:0] value_out_q;
	logic [CNT_W-1:0] count_q;

	logic             out_free;
	logic             commit;
	logic             in_accept;

	logic [KEY_W-1:0] cell_key   [DEPTH];
	logic [KEY_W-1:0] cell_value [DEPTH];
	logic [DEPTH-1:0] hit_vec;
	cell_ctrl_t       ctrl_vec   [DEPTH];

	logic             dup;
	logic             full;
	logic             pos_ok;
	logic [POS_W-1:0] pos_m1;
	logic [IDX_W-1:0] ridx;
	logic [IDX_W-1:0] widx;

	status_t          status_d;
	logic [KEY_W-1:0] key_d;
	logic [KEY_W-1:0] value_d;
	logic [CNT_W-1:0] cnt_d;
	logic             do_insert;
	logic             do_pop;

	assign out_free  = !out_valid_q || !out_stall;
	assign commit    = req_valid_q && out_free;
	assign in_stall  = req_valid_q && !commit;
	assign in_accept = in_valid && !in_stall;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic live;
			assign live = CNT_W'(gi) < cnt_q;
			assign ctrl_vec[gi].shift = commit && do_pop;
			assign ctrl_vec[gi].load  = commit && do_insert && (widx == IDX_W'(gi));

			if (gi == DEPTH - 1) begin : g_last
				ukfq_cell u_cell (
					.clk       (clk),
					.ctrl      (ctrl_vec[gi]),
					.nbr_key   (cell_key[gi]),
					.nbr_value (cell_value[gi]),
					.new_key   (key_s1),
					.new_value (value_s1),
					.cmp_key   (key_s1),
					.live      (live),
					.key       (cell_key[gi]),
					.value     (cell_value[gi]),
					.hit       (hit_vec[gi])
				);
			end else begin : g_mid
				ukfq_cell u_cell (
					.clk       (clk),
					.ctrl      (ctrl_vec[gi]),
					.nbr_key   (cell_key[gi+1]),
					.nbr_value (cell_value[gi+1]),
					.new_key   (key_s1),
					.new_value (value_s1),
					.cmp_key   (key_s1),
					.live      (live),
					.key       (cell_key[gi]),
					.value     (cell_value[gi]),
					.hit       (hit_vec[gi])
				);
			end
		end
	endgenerate

	assign dup    = |hit_vec;
	assign full   = cnt_q == CNT_W'(DEPTH);
	assign pos_ok = (position_s1 != '0) && (CNT_W'(position_s1) <= cnt_q);
	assign pos_m1 = position_s1 - POS_W'(1);
	assign ridx   = pos_m1[IDX_W-1:0];
	assign widx   = cnt_q[IDX_W-1:0];

	always_comb begin
		status_d  = ST_OK;
		key_d     = '0;
		value_d   = '0;
		do_insert = 1'b0;
		do_pop    = 1'b0;
		case (mode_s1)
			MODE_INSERT: begin
				if (dup) begin
					status_d = ST_DUP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					do_insert = 1'b1;
				end
			end
			MODE_POP: begin
				if (cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					do_pop  = 1'b1;
					key_d   = cell_key[0];
					value_d = cell_value[0];
				end
			end
			MODE_READ: begin
				if (pos_ok) begin
					key_d   = cell_key[ridx];
					value_d = cell_value[ridx];
				end else begin
					status_d = ST_EMPTY;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_comb begin
		cnt_d = cnt_q;
		if (do_insert) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (do_pop) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				req_valid_q <= 1'b1;
			end else if (commit) begin
				req_valid_q <= 1'b0;
			end
			if (commit) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result beats
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1     <= mode;
			key_s1      <= key_in;
			value_s1    <= value_in;
			position_s1 <= position;
		end
		if (commit) begin
			status_q    <= status_d;
			key_out_q   <= key_d;
			value_out_q <= value_d;
			count_q     <= cnt_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign key_out   = key_out_q;
	assign value_out = value_out_q;
	assign count     = count_q;

endmodule

`default_nettype wire

// ----- hdl/ukfq_cell.sv -----
`default_nettype none

module ukfq_cell
	import ukfq_pkg::*;
(
	input  wire logic             clk,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [KEY_W-1:0] nbr_key,
	input  wire logic [KEY_W-1:0] nbr_value,
	input  wire logic [KEY_W-1:0] new_key,
	input  wire logic [KEY_W-1:0] new_value,
	input  wire logic [KEY_W-1:0] cmp_key,
	input  wire logic             live,
	output logic      [KEY_W-1:0] key,
	output logic      [KEY_W-1:0] value,
	output logic                  hit
);

	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q   <= new_key;
			value_q <= new_value;
		end else if (ctrl.shift) begin
			key_q   <= nbr_key;
			value_q <= nbr_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign hit   = live && (key_q == cmp_key);

endmodule

`default_nettype wire
